// ===== rtl/ascii_frame_crc_receiver_assert.svh =====
// Assertion macros for the ASCII frame receiver.
`ifndef ASCII_FRAME_CRC_RECEIVER_ASSERT_SVH
`define ASCII_FRAME_CRC_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFCR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afcr assertion failed");

// Next-cycle implication, checked outside reset.
`define AFCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afcr assertion failed");

`endif

// ===== rtl/afcr_pkg.sv =====
// Shared types, constants and helper functions for the ASCII frame receiver.
package afcr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int PAY_CNT_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int PAY_IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [PAY_CNT_W-1:0] PAY_LIMIT = PAY_CNT_W'(MAX_PAYLOAD);

    localparam logic [7:0] CH_START   = 8'h3E;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] HEX_ZERO   = 8'h30;
    localparam logic [7:0] HEX_ALPHA  = 8'h41;

    localparam logic [15:0] CRC_POLY_REV = 16'hA6BC;
    localparam logic [15:0] CRC_XOROUT   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_DATA,
        PH_CHECK,
        PH_ENDNL,
        PH_DROP_PERIOD,
        PH_DROP_LEN,
        PH_DROP_LONG
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_PERIOD    = 3'd1,
        ST_BAD_CSUM_LEN = 3'd2,
        ST_CRC_MISMATCH = 3'd3,
        ST_TOO_LONG     = 3'd4
    } status_t;

    // CRC-16/DNP, reflected, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
        end
        return c;
    endfunction

    // uppercase ASCII hex character for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = HEX_ZERO + {4'h0, nib};
        end
        else
        begin
            r = HEX_ALPHA + {4'h0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ascii_frame_crc_receiver.sv =====
// ASCII framed message receiver with CRC-16/DNP check and buffered payload.
//
// Input channel: rx_byte with rx_valid/rx_stall, one byte per request. Bytes
// outside a frame are dropped; '>' always starts a new frame. Header, payload
// and the CRC update are handled at the accept edge, so a byte is taken every
// cycle while no frame's results are being delivered.
// Output channel: res_valid/res_stall with status, header bytes, data_byte,
// data_valid and last, held in an output register. A good frame gives a
// header request then one request per payload byte; a bad frame gives a
// single status request. Accepting the closing newline starts the queue,
// which then loads the first result into the output register; the rest
// follow one per cycle while res_stall is low. While a frame's results are
// queued out rx_stall is high; a result waiting in the output register
// alone does not stall the input. A stall on the output holds that
// register and the queue; nothing is dropped.
// Config: cfg_valid/cfg_ready write ignore_crc, always ready; write only
// while idle. Reset clears the parser to hunting and empties the output.
`include "ascii_frame_crc_receiver_assert.svh"

module ascii_frame_crc_receiver
    import afcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       ignore_crc,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] status,
    output logic [7:0] asc_version,
    output logic [7:0] app_version,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic       last
);

    phase_t                 phase_reg, phase_next;
    logic [1:0]             header_count_reg, header_count_next;
    logic [15:0]            crc_reg, crc_next;
    logic [PAY_CNT_W-1:0]   payload_count_reg, payload_count_next;
    logic [2:0]             checksum_count_reg, checksum_count_next;
    logic                   mismatch_reg, mismatch_next;
    logic [23:0]            header_store_reg, header_store_next;
    logic                   ignore_crc_reg;
    logic [7:0]             payload_store_reg [MAX_PAYLOAD];

    logic                   job_active_reg, job_active_next;
    status_t                job_status_reg, job_status_next;
    logic [PAY_CNT_W-1:0]   job_idx_reg, job_idx_next;

    logic                   res_valid_reg, res_valid_next;
    status_t                res_status_reg, res_status_next;
    logic [23:0]            res_header_reg, res_header_next;
    logic [7:0]             res_data_reg, res_data_next;
    logic                   res_dv_reg, res_dv_next;
    logic                   res_last_reg, res_last_next;

    logic                   rx_acc;
    logic                   is_start, is_nl, is_period;
    logic                   store_we;
    logic                   job_start;
    status_t                job_status_new;
    logic [15:0]            crc_final;
    logic [3:0]             exp_nib;
    logic                   res_load;
    logic [PAY_CNT_W-1:0]   idx_m1;

    assign rx_stall  = job_active_reg;
    assign rx_acc    = rx_valid && !rx_stall;
    assign cfg_ready = 1'b1;

    assign is_start  = (rx_byte == CH_START);
    assign is_nl     = (rx_byte == CH_NEWLINE);
    assign is_period = (rx_byte == CH_PERIOD);

    assign crc_final = crc_reg ^ CRC_XOROUT;

    // checksum text is most significant nibble first
    always_comb
    begin
        case (checksum_count_reg[1:0])
            2'd0:    exp_nib = crc_final[15:12];
            2'd1:    exp_nib = crc_final[11:8];
            2'd2:    exp_nib = crc_final[7:4];
            default: exp_nib = crc_final[3:0];
        endcase
    end

    // parser next state
    always_comb
    begin
        phase_next = phase_reg;
        if (rx_acc)
        begin
            if (is_start)
            begin
                phase_next = PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (is_nl)
                            phase_next = PH_HUNT;
                        else if (is_period)
                            phase_next = PH_DROP_PERIOD;
                        else if (header_count_reg == 2'd2)
                            phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (is_nl)
                            phase_next = PH_HUNT;
                        else if (is_period)
                            phase_next = PH_CHECK;
                        else if (payload_count_reg >= PAY_LIMIT)
                            phase_next = PH_DROP_LONG;
                    end
                    PH_CHECK:
                    begin
                        if (is_nl)
                            phase_next = PH_HUNT;
                        else if (checksum_count_reg == 3'd3)
                            phase_next = PH_ENDNL;
                    end
                    PH_ENDNL:
                    begin
                        phase_next = is_nl ? PH_HUNT : PH_DROP_LEN;
                    end
                    PH_DROP_PERIOD, PH_DROP_LEN, PH_DROP_LONG:
                    begin
                        if (is_nl)
                            phase_next = PH_HUNT;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // parser datapath and result job launch
    always_comb
    begin
        header_count_next   = header_count_reg;
        crc_next            = crc_reg;
        payload_count_next  = payload_count_reg;
        checksum_count_next = checksum_count_reg;
        mismatch_next       = mismatch_reg;
        header_store_next   = header_store_reg;
        store_we            = 1'b0;
        job_start           = 1'b0;
        job_status_new      = ST_OK;
        if (rx_acc)
        begin
            if (is_start)
            begin
                header_count_next   = 2'd0;
                header_store_next   = 24'h0;
                payload_count_next  = '0;
                checksum_count_next = 3'd0;
                mismatch_next       = 1'b0;
                crc_next            = crc_byte(16'h0000, CH_START);
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (is_nl)
                        begin
                            job_start      = 1'b1;
                            job_status_new = ST_NO_PERIOD;
                        end
                        else if (!is_period)
                        begin
                            crc_next          = crc_byte(crc_reg, rx_byte);
                            header_store_next = {header_store_reg[15:0], rx_byte};
                            header_count_next = header_count_reg + 2'd1;
                        end
                    end
                    PH_DATA:
                    begin
                        if (is_nl)
                        begin
                            job_start      = 1'b1;
                            job_status_new = ST_NO_PERIOD;
                        end
                        else
                        begin
                            crc_next = crc_byte(crc_reg, rx_byte);
                            if (!is_period && (payload_count_reg < PAY_LIMIT))
                            begin
                                store_we           = 1'b1;
                                payload_count_next = payload_count_reg + 1'b1;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        if (is_nl)
                        begin
                            job_start      = 1'b1;
                            job_status_new = ST_BAD_CSUM_LEN;
                        end
                        else
                        begin
                            if (rx_byte != hex_digit(exp_nib))
                                mismatch_next = 1'b1;
                            checksum_count_next = checksum_count_reg + 3'd1;
                        end
                    end
                    PH_ENDNL:
                    begin
                        if (is_nl)
                        begin
                            job_start      = 1'b1;
                            job_status_new = (mismatch_reg && !ignore_crc_reg) ?
                                             ST_CRC_MISMATCH : ST_OK;
                        end
                    end
                    PH_DROP_PERIOD:
                    begin
                        job_start      = is_nl;
                        job_status_new = ST_NO_PERIOD;
                    end
                    PH_DROP_LEN:
                    begin
                        job_start      = is_nl;
                        job_status_new = ST_BAD_CSUM_LEN;
                    end
                    PH_DROP_LONG:
                    begin
                        job_start      = is_nl;
                        job_status_new = ST_TOO_LONG;
                    end
                    default:
                    begin
                        job_start = 1'b0;
                    end
                endcase
            end
        end
    end

    // result queue: header request, then payload bytes, or one status request
    assign res_load = job_active_reg && (!res_valid_reg || !res_stall);
    assign idx_m1   = job_idx_reg - 1'b1;

    always_comb
    begin
        job_active_next = job_active_reg;
        job_status_next = job_status_reg;
        job_idx_next    = job_idx_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_status_next = res_status_reg;
        res_header_next = res_header_reg;
        res_data_next   = res_data_reg;
        res_dv_next     = res_dv_reg;
        res_last_next   = res_last_reg;
        if (job_start)
        begin
            job_active_next = 1'b1;
            job_status_next = job_status_new;
            job_idx_next    = '0;
        end
        else if (res_load)
        begin
            res_valid_next  = 1'b1;
            res_status_next = job_status_reg;
            if (job_status_reg != ST_OK)
            begin
                res_header_next = 24'h0;
                res_data_next   = 8'h00;
                res_dv_next     = 1'b0;
                res_last_next   = 1'b1;
                job_active_next = 1'b0;
            end
            else if (job_idx_reg == '0)
            begin
                res_header_next = header_store_reg;
                res_data_next   = 8'h00;
                res_dv_next     = 1'b0;
                res_last_next   = (payload_count_reg == '0);
                job_active_next = (payload_count_reg != '0);
                job_idx_next    = job_idx_reg + 1'b1;
            end
            else
            begin
                res_header_next = header_store_reg;
                res_data_next   = payload_store_reg[idx_m1[PAY_IDX_W-1:0]];
                res_dv_next     = 1'b1;
                res_last_next   = (job_idx_reg == payload_count_reg);
                job_active_next = (job_idx_reg != payload_count_reg);
                job_idx_next    = job_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            header_count_reg   <= 2'd0;
            crc_reg            <= 16'h0000;
            payload_count_reg  <= '0;
            checksum_count_reg <= 3'd0;
            mismatch_reg       <= 1'b0;
            header_store_reg   <= 24'h0;
            ignore_crc_reg     <= 1'b0;
            job_active_reg     <= 1'b0;
            job_status_reg     <= ST_OK;
            job_idx_reg        <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            crc_reg            <= crc_next;
            payload_count_reg  <= payload_count_next;
            checksum_count_reg <= checksum_count_next;
            mismatch_reg       <= mismatch_next;
            header_store_reg   <= header_store_next;
            if (cfg_valid && cfg_ready)
                ignore_crc_reg <= ignore_crc;
            job_active_reg     <= job_active_next;
            job_status_reg     <= job_status_next;
            job_idx_reg        <= job_idx_next;
            res_valid_reg      <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            payload_store_reg[payload_count_reg[PAY_IDX_W-1:0]] <= rx_byte;
        res_status_reg <= res_status_next;
        res_header_reg <= res_header_next;
        res_data_reg   <= res_data_next;
        res_dv_reg     <= res_dv_next;
        res_last_reg   <= res_last_next;
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign asc_version = res_header_reg[23:16];
    assign app_version = res_header_reg[15:8];
    assign command     = res_header_reg[7:0];
    assign data_byte   = res_data_reg;
    assign data_valid  = res_dv_reg;
    assign last        = res_last_reg;

    `AFCR_ASSERT_IMP(a_status_is_last, res_valid && (status != ST_OK), last && !data_valid)
    `AFCR_ASSERT_IMP(a_job_idx_bound, job_active_reg, job_idx_reg <= payload_count_reg)
    `AFCR_ASSERT_NEXT(a_job_blocks_rx, job_start, rx_stall && job_active_reg)

endmodule
